FILE: sv/rhc_pkg.sv
package rhc_pkg;

  // hue sector offsets, in units of the channel spread d
  localparam int HUE_SECTOR_GREEN = 2;
  localparam int HUE_SECTOR_BLUE  = 4;
  localparam int HUE_TURN         = 6;
  // hue divisor is twice a full turn so that the half-unit bias stays integral
  localparam int HUE_DIV_SCALE    = 12;

  // request queue between classifier and divider pipeline
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: sv/rgb_to_hsl_converter_core.sv
// rgb to hsl converter: one pixel in, one hue / saturation / lightness result out
// throughput: one pixel per cycle while results are taken, set by the fully pipelined
//   restoring dividers, one quotient bit per stage; a held result freezes the dividers
// reset: rst, synchronous active high, empties the input stage, the queue and the
//   divider pipeline; no result is shown until a new pixel is taken
module rgb_to_hsl_converter_core #(
  parameter int CHANNEL_BITS  = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  // pixel requests
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // red, green, blue from the lowest bit up, zero padded to whole bytes
  input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0] s_axis_tdata,
  // hsl results
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // hue, saturation, lightness_sum from the lowest bit up, zero padded to whole bytes
  output logic [((2*FRACTION_BITS+CHANNEL_BITS+9)/8)*8-1:0] m_axis_tdata
);

  localparam int CB     = CHANNEL_BITS;
  localparam int F      = FRACTION_BITS;
  localparam int OUT_W  = ((2*F + CB + 9)/8)*8;
  localparam int ITEM_W = (F+1+CB+4) + (CB+4) + (F+1+CB+1) + (CB+1) + (CB+1);
  localparam logic [F:0]  SAT_FULL = {1'b1, {F{1'b0}}};
  localparam logic [CB:0] LSUM_MAX = {{CB{1'b1}}, 1'b0};

  // front to queue
  logic              push;
  logic [ITEM_W-1:0] front_item;
  // queue to back
  logic              pop;
  logic [ITEM_W-1:0] head_item;
  rhc_pkg::q_stat_t  q_stat;

  logic [F-1:0] hue;
  logic [F:0]   saturation;
  logic [CB:0]  lightness_sum;

  // front: registers the pixel and works out max, min, spread, the hue sector
  // numerator and the saturation denominator, then hands a division request on
  rhc_front #(.CB(CB), .F(F)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .red      (s_axis_tdata[CB-1:0]),
    .green    (s_axis_tdata[2*CB-1:CB]),
    .blue     (s_axis_tdata[3*CB-1:2*CB]),
    .stat     (q_stat),
    .push     (push),
    .item     (front_item)
  );

  // short request queue so the front keeps taking pixels while the output stalls, until full
  rhc_queue #(.W(ITEM_W)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_item),
    .pop   (pop),
    .rdata (head_item),
    .stat  (q_stat)
  );

  // back: two lockstep divider pipelines for hue and saturation; the last stage
  // is the output register
  rhc_back #(.CB(CB), .F(F)) u_back (
    .clk           (clk),
    .rst           (rst),
    .stat          (q_stat),
    .pop           (pop),
    .item          (head_item),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .hue           (hue),
    .saturation    (saturation),
    .lightness_sum (lightness_sum)
  );

  assign m_axis_tdata = OUT_W'({lightness_sum, saturation, hue});

  // saturation never exceeds full scale
  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (saturation <= SAT_FULL))
    else $error("saturation above full scale");

  // zero saturation only for a grey pixel, whose hue is zero too
  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (saturation == '0)) |-> (hue == '0))
    else $error("grey result with nonzero hue");

  // lightness sum stays within twice the channel full scale
  a_lsum_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (lightness_sum <= LSUM_MAX))
    else $error("lightness sum out of range");

  // nothing is shown right after reset
  a_reset_empty: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

FILE: sv/rhc_front.sv
module rhc_front #(
  parameter int CB = 8,
  parameter int F  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CB-1:0]     red,
  input  logic [CB-1:0]     green,
  input  logic [CB-1:0]     blue,
  input  rhc_pkg::q_stat_t  stat,
  output logic              push,
  output logic [(F+1+CB+4)+(CB+4)+(F+1+CB+1)+(CB+1)+(CB+1)-1:0] item
);

  localparam int NUM_W = CB + 3;
  localparam int HN_W  = F + 1 + CB + 4;
  localparam int HD_W  = CB + 4;
  localparam int SN_W  = F + 1 + CB + 1;
  localparam int SD_W  = CB + 1;
  localparam int L_W   = CB + 1;
  localparam logic [CB:0] FULL     = {1'b0, {CB{1'b1}}};
  localparam logic [CB:0] TWO_FULL = {{CB{1'b1}}, 1'b0};

  logic          fv;
  logic [CB-1:0] r, g, b;

  logic [CB-1:0]    mx, mn, d, den;
  logic [CB:0]      sum, den_wide;
  logic             grey;
  logic [NUM_W-1:0] num, two_d, four_d, six_d;
  logic [HN_W-1:0]  hue_n;
  logic [HD_W-1:0]  hue_d;
  logic [SN_W-1:0]  sat_n;
  logic [SD_W-1:0]  sat_d;
  logic [L_W-1:0]   lsum;

  assign in_ready = !fv || !stat.full;
  assign push     = fv && !stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_valid && in_ready) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      r <= red;
      g <= green;
      b <= blue;
    end
  end

  always_comb begin
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    grey     = (mx == mn);
    d        = mx - mn;
    sum      = {1'b0, mx} + {1'b0, mn};
    den_wide = (sum <= FULL) ? sum : (TWO_FULL - sum);
    den      = den_wide[CB-1:0];

    two_d  = NUM_W'(NUM_W'(rhc_pkg::HUE_SECTOR_GREEN) * NUM_W'(d));
    four_d = NUM_W'(NUM_W'(rhc_pkg::HUE_SECTOR_BLUE) * NUM_W'(d));
    six_d  = NUM_W'(NUM_W'(rhc_pkg::HUE_TURN) * NUM_W'(d));

    // max channel checked red, green, blue on ties
    if (mx == r) begin
      if (g >= b) num = NUM_W'(g) - NUM_W'(b);
      else        num = six_d - (NUM_W'(b) - NUM_W'(g));
    end else if (mx == g) begin
      num = two_d + NUM_W'(b) - NUM_W'(r);
    end else begin
      num = four_d + NUM_W'(r) - NUM_W'(g);
    end

    // grey pixel divides zero by one so both quotients come out zero
    if (grey) begin
      hue_n = '0;
      hue_d = HD_W'(1);
      sat_n = '0;
      sat_d = SD_W'(1);
    end else begin
      hue_n = (HN_W'(num) << (F + 1)) + HN_W'(six_d);
      hue_d = HD_W'(HD_W'(rhc_pkg::HUE_DIV_SCALE) * HD_W'(d));
      sat_n = (SN_W'(d) << (F + 1)) + SN_W'(den);
      sat_d = {den, 1'b0};
    end
    lsum = sum;
  end

  assign item = {lsum, sat_d, sat_n, hue_d, hue_n};

endmodule

FILE: sv/rhc_queue.sv
module rhc_queue #(
  parameter int W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [W-1:0]     wdata,
  input  logic             pop,
  output logic [W-1:0]     rdata,
  output rhc_pkg::q_stat_t stat
);

  logic [W-1:0]                   mem [rhc_pkg::QUEUE_DEPTH];
  logic [rhc_pkg::QPTR_BITS-1:0]  wptr, rptr;
  logic [rhc_pkg::QPTR_BITS:0]    count;

  assign stat.full  = (count == (rhc_pkg::QPTR_BITS+1)'(rhc_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign rdata      = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

FILE: sv/rhc_div.sv
module rhc_div #(
  parameter int DW = 12,
  parameter int QW = 17
) (
  input  logic             clk,
  input  logic             en,
  input  logic [QW+DW-1:0] dividend,
  input  logic [DW-1:0]    divisor,
  output logic [QW-1:0]    quotient
);

  // restoring division, one quotient bit per stage; the caller guarantees
  // dividend < divisor * 2^QW so the upper part starts below the divisor
  logic [DW-1:0] rem [QW];
  logic [QW-1:0] low [QW];
  logic [DW-1:0] dv  [QW];
  logic [QW-1:0] quo [QW+1];

  logic [DW:0]   shifted [QW];
  logic [DW:0]   diff    [QW];
  logic          fit     [QW];
  logic [DW-1:0] nrem    [QW];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      shifted[k] = {rem[k], low[k][QW-1]};
      diff[k]    = shifted[k] - {1'b0, dv[k]};
      fit[k]     = (shifted[k] >= {1'b0, dv[k]});
      nrem[k]    = fit[k] ? diff[k][DW-1:0] : shifted[k][DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= dividend[QW+DW-1:QW];
      low[0] <= dividend[QW-1:0];
      dv[0]  <= divisor;
      quo[0] <= '0;
      for (int k = 0; k < QW; k++) begin
        if (k < QW - 1) begin
          rem[k+1] <= nrem[k];
          low[k+1] <= low[k] << 1;
          dv[k+1]  <= dv[k];
        end
        quo[k+1] <= {quo[k][QW-2:0], fit[k]};
      end
    end
  end

  assign quotient = quo[QW];

endmodule

FILE: sv/rhc_back.sv
module rhc_back #(
  parameter int CB = 8,
  parameter int F  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  rhc_pkg::q_stat_t  stat,
  output logic              pop,
  input  logic [(F+1+CB+4)+(CB+4)+(F+1+CB+1)+(CB+1)+(CB+1)-1:0] item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [F-1:0]      hue,
  output logic [F:0]        saturation,
  output logic [CB:0]       lightness_sum
);

  localparam int QW   = F + 1;
  localparam int HN_W = F + 1 + CB + 4;
  localparam int HD_W = CB + 4;
  localparam int SN_W = F + 1 + CB + 1;
  localparam int SD_W = CB + 1;
  localparam int L_W  = CB + 1;

  logic            en;
  logic            v    [QW+1];
  logic [L_W-1:0]  lsum [QW+1];
  logic [HN_W-1:0] hue_n;
  logic [HD_W-1:0] hue_d;
  logic [SN_W-1:0] sat_n;
  logic [SD_W-1:0] sat_d;
  logic [L_W-1:0]  lsum_in;
  logic [QW-1:0]   hue_q, sat_q;

  assign {lsum_in, sat_d, sat_n, hue_d, hue_n} = item;

  // whole pipeline moves together unless the last stage is held
  assign en  = !v[QW] || out_ready;
  assign pop = en && !stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QW; k++) v[k] <= 1'b0;
    end else if (en) begin
      v[0] <= pop;
      for (int k = 1; k <= QW; k++) v[k] <= v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lsum[0] <= lsum_in;
      for (int k = 1; k <= QW; k++) lsum[k] <= lsum[k-1];
    end
  end

  rhc_div #(.DW(HD_W), .QW(QW)) u_hue_div (
    .clk      (clk),
    .en       (en),
    .dividend (hue_n),
    .divisor  (hue_d),
    .quotient (hue_q)
  );

  rhc_div #(.DW(SD_W), .QW(QW)) u_sat_div (
    .clk      (clk),
    .en       (en),
    .dividend (sat_n),
    .divisor  (sat_d),
    .quotient (sat_q)
  );

  assign out_valid     = v[QW];
  assign hue           = hue_q[F-1:0];  // a full turn wraps to zero
  assign saturation    = sat_q;
  assign lightness_sum = lsum[QW];

endmodule
